[hdl/mte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the MIDI track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_ON    = 2'd1,
        KIND_OFF   = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic CFG_TEMPO   = 1'b0;
    localparam logic CFG_PROGRAM = 1'b1;

    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] TEMPO_RESET   = 24'd500000;
    localparam logic [6:0]  PROGRAM_RESET = 7'd4;

    // queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // SMF byte codes
    localparam logic [7:0] B_ZERO       = 8'h00;
    localparam logic [7:0] B_META       = 8'hff;
    localparam logic [7:0] B_META_TEMPO = 8'h51;
    localparam logic [7:0] B_TEMPO_LEN  = 8'h03;
    localparam logic [7:0] B_PROG_CH0   = 8'hc0;
    localparam logic [7:0] B_META_EOT   = 8'h2f;
    localparam logic [7:0] B_NOTE_ON    = 8'h90;
    localparam logic [7:0] B_NOTE_OFF   = 8'h80;
    localparam logic [7:0] B_VLQ_MORE   = 8'h80;
    localparam logic [6:0] DATA_MAX     = 7'h7f;

    // header of a begin item, emitted in nine bytes
    localparam logic [3:0] BEGIN_BYTES = 4'd9;
    localparam logic [3:0] END_BYTES   = 4'd4;
    localparam logic [3:0] NOTE_TAIL   = 4'd3;

    // classified item carried from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] tick;
        logic [6:0]  pitch;
        logic [6:0]  vel;
    } t_item;

    // back sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_back_state;

endpackage

[hdl/mte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_front
// Accepts input words, clamps pitch and velocity and pushes the item.
// ----------------------------------------------------------------------------
module mte_front (
    input  logic                 i_valid,
    input  logic                 i_full,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_tick,
    input  logic signed [8:0]    i_pitch,
    input  logic signed [8:0]    i_velocity,
    output logic                 o_stall,
    output logic                 o_push,
    output mte_pkg::t_item       o_item
);
    import mte_pkg::*;

    t_kind      kind;
    logic [6:0] pitch_c;
    logic [6:0] vel_c;

    assign kind = t_kind'(i_kind);

    always_comb begin
        priority if (i_pitch < 9'sd0) begin
            pitch_c = 7'd0;
        end else if (i_pitch > 9'sd127) begin
            pitch_c = DATA_MAX;
        end else begin
            pitch_c = i_pitch[6:0];
        end
    end

    // note-off always sends velocity zero
    always_comb begin
        priority if (kind != KIND_ON) begin
            vel_c = 7'd0;
        end else if (i_velocity < 9'sd1) begin
            vel_c = 7'd1;
        end else if (i_velocity > 9'sd127) begin
            vel_c = DATA_MAX;
        end else begin
            vel_c = i_velocity[6:0];
        end
    end

    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.kind  = kind;
    assign o_item.tick  = i_tick;
    assign o_item.pitch = pitch_c;
    assign o_item.vel   = vel_c;

endmodule

[hdl/mte_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module mte_fifo #(
    parameter int DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mte_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mte_pkg::t_item  o_item
);
    import mte_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");
`endif

endmodule

[hdl/mte_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_back
// Byte sequencer: takes one item, emits its bytes one per cycle if unstalled.
// ----------------------------------------------------------------------------
module mte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mte_pkg::t_item  i_item,
    output logic            o_pop,
    input  logic [23:0]     i_tempo,
    input  logic [6:0]      i_program,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic [31:0]     o_track_length
);
    import mte_pkg::*;

    t_back_state r_state, n_state;
    t_kind       r_kind;
    logic [6:0]  r_pitch, r_vel;
    logic [31:0] r_delta;
    logic [31:0] r_cursor;
    logic [31:0] r_count;
    logic        r_held_valid;
    logic [6:0]  r_held_byte;
    logic        r_pre;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [31:0] r_out_len;

    logic        pop, emit, out_free, is_last;
    logic [2:0]  vlq_len, grp;
    logic [3:0]  j, n_total;
    logic [7:0]  byte_sel;
    logic [6:0]  grp_bits;
    logic [31:0] count_inc;

    assign pop      = (r_state == ST_IDLE) && !i_empty;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (r_state == ST_EMIT) && out_free;
    assign o_pop    = pop;

    // number of 7-bit groups of the delta
    always_comb begin
        priority if (r_delta[31:28] != '0) begin
            vlq_len = 3'd5;
        end else if (r_delta[27:21] != '0) begin
            vlq_len = 3'd4;
        end else if (r_delta[20:14] != '0) begin
            vlq_len = 3'd3;
        end else if (r_delta[13:7] != '0) begin
            vlq_len = 3'd2;
        end else begin
            vlq_len = 3'd1;
        end
    end

    assign j = r_idx - {3'b000, r_pre};

    always_comb begin
        unique case (r_kind)
            KIND_BEGIN: n_total = BEGIN_BYTES;
            KIND_END:   n_total = END_BYTES + {3'b000, r_pre};
            default:    n_total = NOTE_TAIL + {1'b0, vlq_len} + {3'b000, r_pre};
        endcase
    end

    assign is_last = (r_idx == n_total - 4'd1);

    // VLQ group, most significant first
    assign grp = vlq_len - 3'd1 - j[2:0];

    always_comb begin
        unique case (grp)
            3'd0:    grp_bits = r_delta[6:0];
            3'd1:    grp_bits = r_delta[13:7];
            3'd2:    grp_bits = r_delta[20:14];
            3'd3:    grp_bits = r_delta[27:21];
            default: grp_bits = {3'b000, r_delta[31:28]};
        endcase
    end

    always_comb begin
        byte_sel = B_ZERO;
        if (r_kind == KIND_BEGIN) begin
            unique case (r_idx)
                4'd1:    byte_sel = B_META;
                4'd2:    byte_sel = B_META_TEMPO;
                4'd3:    byte_sel = B_TEMPO_LEN;
                4'd4:    byte_sel = i_tempo[23:16];
                4'd5:    byte_sel = i_tempo[15:8];
                4'd6:    byte_sel = i_tempo[7:0];
                4'd8:    byte_sel = B_PROG_CH0;
                default: byte_sel = B_ZERO;
            endcase
        end else if (r_pre && r_idx == 4'd0) begin
            byte_sel = {1'b0, r_held_byte};
        end else if (r_kind == KIND_END) begin
            unique case (j)
                4'd1:    byte_sel = B_META;
                4'd2:    byte_sel = B_META_EOT;
                default: byte_sel = B_ZERO;
            endcase
        end else begin
            priority if (j < {1'b0, vlq_len}) begin
                byte_sel = {1'b0, grp_bits}
                         | ((j == {1'b0, vlq_len} - 4'd1) ? B_ZERO : B_VLQ_MORE);
            end else if (j == {1'b0, vlq_len}) begin
                byte_sel = (r_kind == KIND_ON) ? B_NOTE_ON : B_NOTE_OFF;
            end else if (j == {1'b0, vlq_len} + 4'd1) begin
                byte_sel = {1'b0, r_pitch};
            end else begin
                byte_sel = {1'b0, r_vel};
            end
        end
    end

    assign count_inc = (r_count == '1) ? r_count : r_count + 32'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (pop) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (emit && is_last) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cursor     <= '0;
            r_count      <= '0;
            r_held_valid <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_idx <= '0;
                if (i_item.kind == KIND_BEGIN) begin
                    r_cursor     <= '0;
                    r_count      <= '0;
                    r_held_valid <= 1'b1;
                end else begin
                    r_held_valid <= 1'b0;
                    if (i_item.kind != KIND_END) begin
                        r_cursor <= i_item.tick;
                    end
                end
            end else if (emit) begin
                r_idx   <= r_idx + 4'd1;
                r_count <= count_inc;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind  <= i_item.kind;
            r_pitch <= i_item.pitch;
            r_vel   <= i_item.vel;
            r_delta <= i_item.tick - r_cursor;
            r_pre   <= (i_item.kind != KIND_BEGIN) && r_held_valid;
            if (i_item.kind == KIND_BEGIN) begin
                r_held_byte <= i_program;
            end
        end
        if (emit) begin
            r_out_byte <= byte_sel;
            r_out_last <= is_last;
            r_out_len  <= count_inc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last         = r_out_last;
    assign o_track_length = r_out_len;

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_idx < BEGIN_BYTES)
        else $error("byte index past nine");

    a_begin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_item.kind == KIND_BEGIN |=> r_held_valid && r_count == '0)
        else $error("begin did not hold program byte or clear count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && is_last |=> r_state == ST_IDLE && o_out_valid && o_last)
        else $error("last byte did not end the item");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> !pop)
        else $error("pop while emitting");
`endif

endmodule

[hdl/midi_track_event_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_encoder_core
// Encodes begin / note-on / note-off / end items into SMF track body bytes.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one item word (kind, tick,
//   pitch, velocity). o_in_stall is high only while the item queue is full.
// Output channel: o_out_valid / i_out_stall carry one byte word with its
//   last flag and the running track length. A word is taken on an edge with
//   o_out_valid high and i_out_stall low.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0 tempo,
//   1 program) at the edge; write only while the block is idle.
// With the back idle, an accepted item is first written into the queue, then
//   loaded by the back, and its first byte is then registered at the output.
// The back emits one byte per cycle unless the output stalls, and loads a new
//   item only when idle; items are begin 9, note 4..9 or end 4..5 bytes long.
// The front keeps taking items into the queue while the back is busy.
// Reset clears the cursor, byte count, held program byte and the queue; the
//   tempo and program registers return to 500000 and 4.
// When the receiver stalls, the output word holds and the sequencer waits;
//   the queue then fills and o_in_stall rises.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_core #(
    parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [31:0]                    i_tick,
    input  logic signed [8:0]              i_pitch,
    input  logic signed [8:0]              i_velocity,
    // byte output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last,
    output logic [31:0]                    o_track_length,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mte_pkg::*;

    logic [23:0] r_tempo;
    logic [6:0]  r_program;

    // front to queue
    logic  push, full, empty, pop;
    t_item front_item, queue_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo   <= TEMPO_RESET;
            r_program <= PROGRAM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMPO:   r_tempo   <= i_cfg_data[23:0];
                CFG_PROGRAM: r_program <= i_cfg_data[6:0];
                default:     r_tempo   <= r_tempo;
            endcase
        end
    end

    // front: handshake and clamping
    mte_front u_front (
        .i_valid    (i_in_valid),
        .i_full     (full),
        .i_kind     (i_kind),
        .i_tick     (i_tick),
        .i_pitch    (i_pitch),
        .i_velocity (i_velocity),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_item     (front_item)
    );

    // decoupling queue
    mte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    // back: delta, VLQ and byte sequencing
    mte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .i_tempo        (r_tempo),
        .i_program      (r_program),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_track_length (o_track_length)
    );

endmodule
